>>> design/random_envelope_noise_gen_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the random envelope noise generator
// Concurrent checks that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef RANDOM_ENVELOPE_NOISE_GEN_ASSERT_SVH
`define RANDOM_ENVELOPE_NOISE_GEN_ASSERT_SVH

`ifndef ASSERT_OFF

// Property that must hold at every clock edge outside of reset.
`define RENG_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define RENG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RENG_ASSERT(lbl, clk, rst_n, prop, msg)
`define RENG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> design/reng_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Random envelope noise generator package
// Field widths, register indexes, reset values and envelope constants.
// ----------------------------------------------------------------------------
package reng_pkg;

    localparam int PHASE_W  = 32;
    localparam int AMP_W    = 16;
    localparam int BREAK_W  = 15;
    localparam int SAMPLE_W = 20;
    localparam int SHIFT_W  = 5;
    localparam int ENV_W    = 32;
    localparam int ENV_FRAC = 10;
    localparam int AMP_FRAC = 15;
    localparam int LEVEL_W  = BREAK_W + ENV_FRAC;
    localparam int MENV_W   = ENV_W - ENV_FRAC;
    localparam int PROD_W   = MENV_W + AMP_W;

    localparam logic [SHIFT_W-1:0]     STEP_SHIFT_RESET = 5'd6;
    localparam logic                   CLAMP_RESET      = 1'b1;
    localparam logic signed [ENV_W-1:0] RETRIG_LEVEL    = 32'sd10;

    typedef enum logic [0:0] {
        CFG_STEP_SHIFT   = 1'b0,
        CFG_CLAMP_ENABLE = 1'b1
    } t_cfg_idx;

endpackage

>>> design/reng_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Random envelope noise generator channels
// Input word, result word and configuration write channels.
// ----------------------------------------------------------------------------
interface reng_in_if import reng_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [PHASE_W-1:0]        phase_inc;
    logic signed [AMP_W-1:0]   rand_amplitude;
    logic [BREAK_W-1:0]        rand_break;

    modport source (output valid, output phase_inc, output rand_amplitude,
                    output rand_break, input ready);
    modport sink   (input valid, input phase_inc, input rand_amplitude,
                    input rand_break, output ready);
endinterface

interface reng_out_if import reng_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface reng_cfg_if import reng_pkg::*; ();
    logic               valid;
    logic               ready;
    t_cfg_idx           index;
    logic [SHIFT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/random_envelope_noise_gen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Random envelope noise generator
// Shapes externally supplied random amplitude and break levels with a
// rising and falling envelope and scales each tick into a noise sample.
// ----------------------------------------------------------------------------
// Usage:
// Each word on i_in is one sample tick carrying the phase increment and a
// fresh random amplitude and break level. The block returns exactly one
// sample word on o_out for every accepted input word, in order.
// The pipeline has three registers: the input register, an envelope stage
// that updates the envelope state and holds the scaled envelope and
// amplitude, and the output register that holds the product. A word
// therefore passes from the input register through the envelope stage to the
// output register, and one word is taken in every cycle while the receiver
// does not stall; the envelope state update is the loop that sets this rate.
// i_cfg writes step_shift (index 0) and clamp_enable (index 1); it is always
// ready and should only be written while the pipeline is empty.
// Reset (i_rst_n low, synchronous) empties the pipeline, clears the
// envelope, the rising flag, the amplitude and the break level, and loads
// step_shift = 6 and clamp_enable = 1.
// When the receiver stalls, the result is held in the output register and
// the earlier stages keep filling until all three are occupied; only then
// does i_in.ready drop.
// ----------------------------------------------------------------------------
`include "random_envelope_noise_gen_assert.svh"

module random_envelope_noise_gen
    import reng_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    reng_in_if.sink    i_in,
    reng_out_if.source o_out,
    reng_cfg_if.sink   i_cfg
);

    // Configuration registers.
    logic [SHIFT_W-1:0] r_step_shift;
    logic               r_clamp_enable;

    // Input register.
    logic                    r_s1_valid;
    logic [PHASE_W-1:0]      r_phase_inc;
    logic signed [AMP_W-1:0] r_rand_amp;
    logic [BREAK_W-1:0]      r_rand_break;

    // Envelope state.
    logic [ENV_W-1:0]        r_env_level;
    logic                    r_rising;
    logic signed [AMP_W-1:0] r_amplitude;
    logic [LEVEL_W-1:0]      r_break_level;

    // Envelope stage toward the multiplier.
    logic                     r_s2_valid;
    logic signed [MENV_W-1:0] r_mul_env;
    logic signed [AMP_W-1:0]  r_mul_amp;

    // Output register.
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_sample;

    // Next values of the envelope state.
    logic [ENV_W-1:0]        n_env_level;
    logic                    n_rising;
    logic signed [AMP_W-1:0] n_amplitude;
    logic [LEVEL_W-1:0]      n_break_level;

    logic                     w_out_free;
    logic                     w_s2_free;
    logic                     w_s1_free;
    logic                     w_fire;
    logic [ENV_W-1:0]         w_step;
    logic [ENV_W-1:0]         w_env_step;
    logic [ENV_W-1:0]         w_break_ext;
    logic signed [PROD_W-1:0] w_prod;

    // Each stage moves when the one after it is empty or moving.
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_s2_free  = !r_s2_valid || w_out_free;
    assign w_s1_free  = !r_s1_valid || w_s2_free;
    assign w_fire     = r_s1_valid && w_s2_free;

    assign i_in.ready   = w_s1_free;
    assign i_cfg.ready  = 1'b1;
    assign o_out.valid  = r_out_valid;
    assign o_out.sample = r_sample;

    // ---- Configuration -----------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_shift   <= STEP_SHIFT_RESET;
            r_clamp_enable <= CLAMP_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_STEP_SHIFT:   r_step_shift   <= i_cfg.data;
                CFG_CLAMP_ENABLE: r_clamp_enable <= i_cfg.data[0];
            endcase
        end
    end

    // ---- Input register ----------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_free) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_free) begin
            r_phase_inc  <= i_in.phase_inc;
            r_rand_amp   <= i_in.rand_amplitude;
            r_rand_break <= i_in.rand_break;
        end
    end

    // ---- Envelope update ---------------------------------------------------
    // The step is the phase increment scaled down by the configured shift.
    // While rising the envelope climbs until it meets the break level, else
    // it falls. All comparisons treat the envelope as signed 32 bits.
    assign w_step      = r_phase_inc >> r_step_shift;
    assign w_break_ext = {{(ENV_W-LEVEL_W){1'b0}}, r_break_level};
    assign w_env_step  = r_rising ? (r_env_level + w_step) : (r_env_level - w_step);

    always_comb begin
        n_env_level   = w_env_step;
        n_rising      = r_rising;
        n_amplitude   = r_amplitude;
        n_break_level = r_break_level;

        if (r_rising) begin
            if ($signed(w_env_step) >= $signed(w_break_ext)) begin
                n_rising = 1'b0;
                if (r_clamp_enable) begin
                    n_env_level = w_break_ext;
                end
            end
        end else if (r_clamp_enable && w_env_step[ENV_W-1]) begin
            n_env_level = '0;
        end

        // A low envelope retriggers with a new amplitude and break level.
        if ($signed(n_env_level) < RETRIG_LEVEL) begin
            n_amplitude   = r_rand_amp;
            n_break_level = {r_rand_break, {ENV_FRAC{1'b0}}};
            n_rising      = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_env_level   <= '0;
            r_rising      <= 1'b0;
            r_amplitude   <= '0;
            r_break_level <= '0;
        end else if (w_fire) begin
            r_env_level   <= n_env_level;
            r_rising      <= n_rising;
            r_amplitude   <= n_amplitude;
            r_break_level <= n_break_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_s2_free) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    // The arithmetic shift of the envelope is just its upper bits.
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_mul_env <= $signed(n_env_level[ENV_W-1:ENV_FRAC]);
            r_mul_amp <= n_amplitude;
        end
    end

    // ---- Scaling multiply --------------------------------------------------
    // 22 by 16 bit signed product; the sample is bits 34..15, which wraps
    // out-of-range results to 20 bits.
    assign w_prod = r_mul_env * r_mul_amp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_sample <= w_prod[AMP_FRAC+SAMPLE_W-1:AMP_FRAC];
        end
    end

    // ---- Assertions --------------------------------------------------------
    // After an update the envelope is either at or above the retrigger level
    // or the block is rising again.
    `RENG_ASSERT_NEXT(a_retrigger_rises, i_clk, i_rst_n, w_fire,
        ($signed(r_env_level) >= RETRIG_LEVEL) || r_rising,
        "envelope below retrigger level without rising")
    // With clamping on, a falling update never leaves a negative envelope.
    `RENG_ASSERT_NEXT(a_clamp_floor, i_clk, i_rst_n,
        w_fire && r_clamp_enable && !r_rising, !r_env_level[ENV_W-1],
        "clamped envelope fell below zero")
    // The latched amplitude only changes when a word passes the envelope.
    `RENG_ASSERT_NEXT(a_amp_hold, i_clk, i_rst_n, !w_fire, $stable(r_amplitude),
        "amplitude changed without an envelope update")
    // A word that passes the envelope stage always lands in the next stage.
    `RENG_ASSERT_NEXT(a_stage_fill, i_clk, i_rst_n, w_fire, r_s2_valid,
        "envelope stage lost a word")

endmodule

>>> tb/random_envelope_noise_gen_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Random envelope noise generator testbench
// Drives sample ticks and register writes into the generator, predicts every
// output word with a cycle-free envelope model kept in step with accepted
// ticks, and compares the returned samples in order under random idling,
// a long output hold-off and several step shift and clamp settings.
// ----------------------------------------------------------------------------
module random_envelope_noise_gen_test
    import reng_pkg::*;
();

    // Three pipeline registers, plus a little margin before a register write.
    localparam int SETTLE_CYCLES = 6;
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_PER_SETTING = 220;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    reng_in_if  in_if ();
    reng_out_if out_if ();
    reng_cfg_if cfg_if ();

    random_envelope_noise_gen u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Envelope predictor state. It starts from the reset values and moves only
    // when the block accepts a tick or a register write.
    // ------------------------------------------------------------------------
    logic [ENV_W-1:0]        env_level_q  = '0;
    logic                    env_rising_q = 1'b0;
    logic signed [AMP_W-1:0] env_amp_q    = '0;
    logic [LEVEL_W-1:0]      env_break_q  = '0;
    logic [SHIFT_W-1:0]      cfg_shift    = STEP_SHIFT_RESET;
    logic                    cfg_clamp    = CLAMP_RESET;

    // Samples still owed by the block, oldest first.
    logic [SAMPLE_W-1:0] pending_samples [$];

    int  mismatches         = 0;
    int  samples_checked    = 0;
    int  ticks_sent         = 0;
    int  reg_writes         = 0;
    int  retriggers         = 0;
    int  break_crossings    = 0;
    int  input_stall_cycles = 0;

    // Idling controls shared by the sender and the receiver.
    bit  src_idle_en   = 1'b0;
    bit  sink_idle_en  = 1'b0;
    int  hold_off_left = 0;

    // Phase increment held over a run of ticks, as a running oscillator would.
    logic [PHASE_W-1:0] held_phase = '0;
    int                 held_left  = 0;

    // Advances the envelope by one tick and returns the sample it produces.
    function automatic logic [SAMPLE_W-1:0] next_sample(
        input logic [PHASE_W-1:0]      phase,
        input logic signed [AMP_W-1:0] amp_in,
        input logic [BREAK_W-1:0]      brk_in
    );
        logic [ENV_W-1:0]         step;
        logic signed [MENV_W-1:0] env_int;
        longint                   prod;
        step = phase >> cfg_shift;
        if (env_rising_q) begin
            env_level_q = env_level_q + step;
            // Signed compare against the zero-extended break level.
            if ($signed(env_level_q) >= $signed({{(ENV_W-LEVEL_W){1'b0}}, env_break_q})) begin
                env_rising_q = 1'b0;
                break_crossings++;
                if (cfg_clamp) begin
                    env_level_q = {{(ENV_W-LEVEL_W){1'b0}}, env_break_q};
                end
            end
        end else begin
            env_level_q = env_level_q - step;
            if (cfg_clamp && $signed(env_level_q) < 0) begin
                env_level_q = '0;
            end
        end
        // Near the floor a fresh amplitude and break level are taken, even
        // when the envelope is still rising.
        if ($signed(env_level_q) < RETRIG_LEVEL) begin
            env_amp_q    = amp_in;
            env_break_q  = {brk_in, {ENV_FRAC{1'b0}}};
            env_rising_q = 1'b1;
            retriggers++;
        end
        // The top bits of the envelope are its arithmetic shift right.
        env_int = env_level_q[ENV_W-1:ENV_FRAC];
        prod = longint'(env_int) * longint'(env_amp_q);
        return prod[AMP_FRAC +: SAMPLE_W];
    endfunction

    // ------------------------------------------------------------------------
    // Result side: the receiver's ready, with random stall bursts and an
    // optional long hold-off that the backpressure test arms.
    // ------------------------------------------------------------------------
    initial begin : drive_sample_ready
        int burst;
        burst = 0;
        out_if.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_off_left > 0) begin
                hold_off_left--;
                out_if.ready <= 1'b0;
            end else if (burst > 0) begin
                burst--;
                out_if.ready <= 1'b0;
            end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 14) - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // Every accepted sample word is matched against the oldest pending one.
    always @(posedge clk) begin : check_samples
        logic [SAMPLE_W-1:0] want;
        if (rst_n) begin
            if (in_if.valid && !in_if.ready) begin
                input_stall_cycles++;
            end
            if (out_if.valid && out_if.ready) begin
                if (pending_samples.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("unexpected sample word %0d with nothing pending",
                                 $signed(out_if.sample));
                    end
                end else begin
                    want = pending_samples.pop_front();
                    samples_checked++;
                    if (out_if.sample !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("sample word %0d: expected %0d, got %0d",
                                     samples_checked, $signed(want),
                                     $signed(out_if.sample));
                        end
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks. Valid is left high after a word is taken so that back to
    // back words need only one assignment per edge; it is lowered only when
    // the sender idles or stops.
    // ------------------------------------------------------------------------
    task automatic send_tick(
        input logic [PHASE_W-1:0]      phase,
        input logic signed [AMP_W-1:0] amp,
        input logic [BREAK_W-1:0]      brk
    );
        int gap;
        gap = (src_idle_en && $urandom_range(0, 5) == 0) ? $urandom_range(1, 14) : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid          <= 1'b1;
        in_if.phase_inc      <= phase;
        in_if.rand_amplitude <= amp;
        in_if.rand_break     <= brk;
        do @(posedge clk); while (!in_if.ready);
        pending_samples.push_back(next_sample(phase, amp, brk));
        ticks_sent++;
    endtask

    // Stops sending and waits for the pipeline to drain completely.
    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [SHIFT_W-1:0] value);
        wait_idle();
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        if (idx == CFG_STEP_SHIFT) begin
            cfg_shift = value;
        end else begin
            cfg_clamp = value[0];
        end
        reg_writes++;
    endtask

    task automatic apply_setting(input logic [SHIFT_W-1:0] shift, input logic clamp);
        write_reg(CFG_STEP_SHIFT, shift);
        write_reg(CFG_CLAMP_ENABLE, {{(SHIFT_W-1){1'b0}}, clamp});
    endtask

    // Random ticks: mostly a held phase increment so that envelopes run full
    // rise and fall cycles, with occasional wild increments and extreme fields.
    task automatic run_random(input int count, input bit idling);
        logic [PHASE_W-1:0]      phase;
        logic signed [AMP_W-1:0] amp;
        logic [BREAK_W-1:0]      brk;
        int                      pick;
        for (int i = 0; i < count; i++) begin
            if (i % 50 == 0) begin
                src_idle_en  = idling && ($urandom_range(0, 2) != 0);
                sink_idle_en = idling && ($urandom_range(0, 2) != 0);
            end
            if (held_left == 0) begin
                // Log-spread magnitude so that steps span tiny to huge.
                held_phase = $urandom >> $urandom_range(0, 31);
                held_left  = $urandom_range(1, 64);
            end
            held_left--;
            phase = ($urandom_range(0, 9) == 0) ? $urandom : held_phase;
            pick = $urandom_range(0, 19);
            case (pick)
                0: begin
                    amp = 16'sh8000;
                end
                1: begin
                    amp = 16'sh7FFF;
                end
                2: begin
                    amp = 16'sh8001;
                end
                default: begin
                    amp = AMP_W'($urandom);
                end
            endcase
            if (pick == 3) begin
                brk = '0;
            end else if (pick == 4) begin
                brk = '1;
            end else begin
                brk = BREAK_W'($urandom);
            end
            send_tick(phase, amp, brk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset settings (shift 6, clamping on): retrigger from the cleared state,
    // clamping at the break level and at zero, the most negative amplitude,
    // a zero break level and a retrigger while still rising.
    task automatic test_directed_reset_state();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        send_tick(32'h0000_0000, 16'sh7FFF, 15'h7FFF);
        send_tick(32'h0010_0000, 16'shFFFF, 15'h0000);
        send_tick(32'hFFFF_FFFF, 16'sh0000, 15'h0000);
        send_tick(32'h0400_0000, 16'sh0000, 15'h0000);
        send_tick(32'hFFFF_FFFF, 16'sh8000, 15'h7FFF);
        send_tick(32'hFFFF_FFFF, 16'sh1234, 15'h2AAA);
        send_tick(32'hFFFF_FFFF, 16'sh8001, 15'h0000);
        send_tick(32'h0000_0400, 16'sh5555, 15'h5555);
        send_tick(32'h0000_003F, 16'shAAAA, 15'h2AAA);
        wait_idle();
    endtask

    // Shift 0 with clamping off: the envelope wraps through the signed range,
    // overshoots both ends and drives the sample past its 20-bit range.
    task automatic test_overflow_unclamped();
        apply_setting(5'd0, 1'b0);
        send_tick(32'hFFFF_FFF0, 16'sh7FFF, 15'h7FFF);
        send_tick(32'h7FFF_FFFF, 16'sh8000, 15'h0001);
        send_tick(32'h7FFF_FFFF, 16'sh8000, 15'h0001);
        send_tick(32'h8000_0000, 16'sh4000, 15'h4000);
        send_tick(32'hFFFF_FFFF, 16'sh0001, 15'h7FFF);
        send_tick(32'h0000_0001, 16'shAAAA, 15'h2AAA);
        send_tick(32'h5555_5555, 16'sh5555, 15'h5555);
        send_tick(32'hAAAA_AAAA, 16'sh8000, 15'h7FFF);
        send_tick(32'hFFFF_FFFF, 16'sh7FFF, 15'h0000);
        send_tick(32'h7FFF_FFFF, 16'sh8001, 15'h7FFF);
        wait_idle();
    endtask

    // Random ticks across a spread of settings, both shift extremes included.
    task automatic test_random_settings();
        logic [SHIFT_W-1:0] shifts [8] = '{5'd4, 5'd4, 5'd6, 5'd0, 5'd31, 5'd0, 5'd31, 5'd5};
        logic               clamps [8] = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
        for (int s = 0; s < 8; s++) begin
            apply_setting(shifts[s], clamps[s]);
            run_random(RANDOM_PER_SETTING, 1'b1);
        end
    endtask

    // The receiver holds off for a long stretch while words keep coming, so
    // the pipeline fills and input ready drops; afterwards the sender waits
    // until every pending sample has come back.
    task automatic test_output_backpressure();
        apply_setting(5'd4, 1'b1);
        src_idle_en   = 1'b0;
        sink_idle_en  = 1'b0;
        hold_off_left = 80;
        for (int i = 0; i < 60; i++) begin
            send_tick($urandom >> $urandom_range(4, 12), AMP_W'($urandom),
                      BREAK_W'($urandom));
        end
        wait_idle();
    endtask

    // Closing stretch with a random setting and no idling on either side.
    task automatic test_quiet_tail();
        apply_setting(SHIFT_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
        run_random(160, 1'b0);
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
    endtask

    initial begin : run_tests
        in_if.valid          = 1'b0;
        in_if.phase_inc      = '0;
        in_if.rand_amplitude = '0;
        in_if.rand_break     = '0;
        cfg_if.valid         = 1'b0;
        cfg_if.index         = CFG_STEP_SHIFT;
        cfg_if.data          = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed_reset_state();
        test_overflow_unclamped();
        test_random_settings();
        test_output_backpressure();
        test_quiet_tail();

        // Drain, then give the pipeline time to show any stray word.
        wait_idle();
        repeat (10) @(posedge clk);

        $display("Run covered %0d ticks and %0d checked samples over %0d register writes.",
                 ticks_sent, samples_checked, reg_writes);
        $display("Envelope retriggered %0d times, crossed its break level %0d times;",
                 retriggers, break_crossings);
        $display("the input stalled for %0d cycles.", input_stall_cycles);
        if (mismatches == 0 && pending_samples.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of this stimulus.
    initial begin : watchdog
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

>>> random_envelope_noise_gen.f
+incdir+design
design/reng_pkg.sv
design/reng_if.sv
design/random_envelope_noise_gen.sv
tb/random_envelope_noise_gen_test.sv
